@@ rtl/frm_rx_pkg.sv @@
// ----------------------------------------------------------------------------
// frm_rx_pkg
// Shared types and constants for the framed message receiver.
// ----------------------------------------------------------------------------
package frm_rx_pkg;

  localparam logic [7:0] START_BYTE     = 8'h0A;
  localparam logic [7:0] MIN_LENGTH     = 8'd3;
  localparam logic [7:0] MAX_LENGTH_RST = 8'd64;

  typedef enum logic [1:0] {
    STATUS_NONE    = 2'd0,
    STATUS_OK      = 2'd1,
    STATUS_SUM_ERR = 2'd2,
    STATUS_LEN_ERR = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic          payload_valid;
    logic [7:0]    payload_byte;
    logic [7:0]    payload_index;
    frame_status_t frame_status;
  } frm_result_t;

endpackage

@@ rtl/framed_message_receiver_core.sv @@
// ----------------------------------------------------------------------------
// framed_message_receiver_core
// Hunts for start byte 0x0A, takes the next byte as total frame length L
// (start, length, body, checksum), emits the L-3 body bytes with their index
// and checks the last byte against the mod-256 sum of the body. Every input
// transaction yields exactly one output transaction. A byte passes through an
// input register and a result register, and a new byte is taken every cycle
// while the output is not stalled. The user must write max_length through the
// cfg port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module framed_message_receiver_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic [1:0] frame_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import frm_rx_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic [7:0]  max_length;
  logic        advance;
  logic        step;
  logic        in_fire;
  frm_result_t result;
  frm_result_t out_result;

  assign advance  = !out_valid || !out_stall;
  assign step     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign in_fire  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte <= rx_byte;
    end
  end

  frm_rx_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (s1_byte),
    .max_length (max_length),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= result;
    end
  end

  assign payload_valid = out_result.payload_valid;
  assign payload_byte  = out_result.payload_byte;
  assign payload_index = out_result.payload_index;
  assign frame_status  = out_result.frame_status;

`ifndef SYNTH
  a_payload_no_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> frame_status == STATUS_NONE)
    else $error("payload byte reported together with a frame status");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 8'd0)
    else $error("nonzero payload fields without payload_valid");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

@@ rtl/frm_rx_parser.sv @@
// ----------------------------------------------------------------------------
// frm_rx_parser
// Frame state (position, length, checksum) and per-byte result decode.
// ----------------------------------------------------------------------------
module frm_rx_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              rx_byte,
  input  logic [7:0]              max_length,
  output frm_rx_pkg::frm_result_t result
);
  import frm_rx_pkg::*;

  logic [7:0] byte_position;
  logic [7:0] byte_position_next;
  logic [7:0] expected_length;
  logic [7:0] expected_length_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic       in_body;

  assign in_body = ({1'b0, byte_position} + 9'd1) < {1'b0, expected_length};

  always_comb begin
    byte_position_next   = byte_position;
    expected_length_next = expected_length;
    running_sum_next     = running_sum;
    result               = '{payload_valid: 1'b0, payload_byte: 8'd0,
                             payload_index: 8'd0, frame_status: STATUS_NONE};
    if (byte_position == 8'd0) begin
      if (rx_byte == START_BYTE) begin
        byte_position_next = 8'd1;
      end
    end else if (byte_position == 8'd1) begin
      if (rx_byte > max_length || rx_byte < MIN_LENGTH) begin
        result.frame_status  = STATUS_LEN_ERR;
        byte_position_next   = 8'd0;
        expected_length_next = 8'd0;
        running_sum_next     = 8'd0;
      end else begin
        expected_length_next = rx_byte;
        running_sum_next     = 8'd0;
        byte_position_next   = 8'd2;
      end
    end else if (in_body) begin
      result.payload_valid = 1'b1;
      result.payload_byte  = rx_byte;
      result.payload_index = byte_position - 8'd2;
      running_sum_next     = running_sum + rx_byte;
      byte_position_next   = byte_position + 8'd1;
    end else begin
      result.frame_status  = (rx_byte == running_sum) ? STATUS_OK : STATUS_SUM_ERR;
      byte_position_next   = 8'd0;
      expected_length_next = 8'd0;
      running_sum_next     = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 8'd0;
      expected_length <= 8'd0;
      running_sum     <= 8'd0;
    end else if (step) begin
      byte_position   <= byte_position_next;
      expected_length <= expected_length_next;
      running_sum     <= running_sum_next;
    end
  end

endmodule
